// ===== sv/zfrd_pkg.sv =====
package zfrd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  byte_out;
    logic [17:0] run_length;
    logic [3:0]  error_code;
    logic        stream_last;
  } result_t;

  localparam logic [31:0] ZSTD_MAGIC = 32'hfd2fb528;
  localparam logic [31:0] SKIP_BASE  = 32'h184d2a50;
  localparam logic [31:0] SKIP_MASK  = 32'hfffffff0;

  localparam logic       KIND_BYTE = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] RES_LITERAL = 2'd0;
  localparam logic [1:0] RES_RUN     = 2'd1;
  localparam logic [1:0] RES_DONE    = 2'd2;
  localparam logic [1:0] RES_ERROR   = 2'd3;

  localparam logic [3:0] ERR_TRUNCATED    = 4'd0;
  localparam logic [3:0] ERR_BAD_MAGIC    = 4'd1;
  localparam logic [3:0] ERR_RESERVED_BIT = 4'd2;
  localparam logic [3:0] ERR_DICTIONARY   = 4'd3;
  localparam logic [3:0] ERR_ZERO_WINDOW  = 4'd4;
  localparam logic [3:0] ERR_WINDOW_LIMIT = 4'd5;
  localparam logic [3:0] ERR_CONTENT_LIM  = 4'd6;
  localparam logic [3:0] ERR_ZERO_BLKMAX  = 4'd7;
  localparam logic [3:0] ERR_RESERVED_BLK = 4'd8;
  localparam logic [3:0] ERR_BLOCK_BIG    = 4'd9;
  localparam logic [3:0] ERR_OUTPUT_LIMIT = 4'd10;
  localparam logic [3:0] ERR_COMPRESSED   = 4'd11;
  localparam logic [3:0] ERR_SIZE_MISMATCH = 4'd12;

  localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd0;
  localparam logic [1:0] REG_WINDOW_LIMIT = 2'd1;

  localparam logic [1:0] BTYPE_RAW  = 2'd0;
  localparam logic [1:0] BTYPE_RLE  = 2'd1;
  localparam logic [1:0] BTYPE_COMP = 2'd2;
  localparam logic [1:0] BTYPE_RSVD = 2'd3;

  typedef enum logic [11:0] {
    PH_MAGIC     = 12'b0000_0000_0001,
    PH_SKIP_SIZE = 12'b0000_0000_0010,
    PH_SKIP_BODY = 12'b0000_0000_0100,
    PH_DESC      = 12'b0000_0000_1000,
    PH_WINDOW    = 12'b0000_0001_0000,
    PH_DICT      = 12'b0000_0010_0000,
    PH_FCS       = 12'b0000_0100_0000,
    PH_BLK_HDR   = 12'b0000_1000_0000,
    PH_RAW       = 12'b0001_0000_0000,
    PH_RLE       = 12'b0010_0000_0000,
    PH_COMP      = 12'b0100_0000_0000,
    PH_CHECKSUM  = 12'b1000_0000_0000
  } phase_t;

  // length in bytes of the frame content size field
  function automatic logic [3:0] fcs_len(input logic [1:0] code, input logic single);
    logic [3:0] n;
    unique case (code)
      2'd0: n = single ? 4'd1 : 4'd0;
      2'd1: n = 4'd2;
      2'd2: n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/zstd_frame_raw_rle_decoder_unit.sv =====
// Zstandard frame parser for raw and RLE blocks.
// Input channel: item_valid / item_stall / item, one stream word (byte or end
// marker) per accepted word. Output channel: result_valid / result_stall /
// result, at most one result word per input word: a literal byte, a run
// (byte and count), stream done, or an error code.
// A result is registered: it appears on the outputs in the cycle after the input
// word that caused it is accepted. The parser takes one input word per cycle
// while item_stall is low, and updates its state for each accepted byte.
// The result register sits between parser and receiver; while the receiver
// stalls a waiting result, item_stall is raised and the parser holds.
// After an error, bytes are dropped until the end marker, which gives no result
// and starts a fresh stream. Output already sent before an error stays sent.
// Configuration (output_limit, window_limit) is written through cfg_we / cfg_index /
// cfg_data, only while the block is idle: a rule for the user, not enforced.
// Reset (rst, synchronous) empties the result register, restores the limits to
// their defaults and puts the parser back to expecting a frame magic.
module zstd_frame_raw_rle_decoder_unit import zfrd_pkg::*; #(
  parameter int BLOCK_SIZE_CAP = 131072
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] output_limit;
  logic [31:0] window_limit;
  logic        take;
  logic        res_valid;
  result_t     res;

  assign item_stall = result_valid && result_stall;
  assign take = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= 32'd16777216;
      window_limit <= 32'd8388608;
    end else if (cfg_we) begin
      if (cfg_index == REG_OUTPUT_LIMIT) output_limit <= cfg_data;
      if (cfg_index == REG_WINDOW_LIMIT) window_limit <= cfg_data;
    end
  end

  zfrd_parser #(.BLOCK_SIZE_CAP(BLOCK_SIZE_CAP)) u_parser (
    .clk(clk), .rst(rst), .take(take), .item(item),
    .output_limit(output_limit), .window_limit(window_limit),
    .res_valid(res_valid), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!item_stall) begin
      result_valid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && take && res_valid) result <= res;
  end

endmodule

// ===== sv/zfrd_parser.sv =====
module zfrd_parser import zfrd_pkg::*; #(
  parameter int BLOCK_SIZE_CAP = 131072
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  item_t       item,
  input  logic [31:0] output_limit,
  input  logic [31:0] window_limit,
  output logic        res_valid,
  output result_t     res
);

  localparam int BMW = $clog2(BLOCK_SIZE_CAP + 1);
  localparam logic [63:0] CAP64 = 64'(BLOCK_SIZE_CAP);

  phase_t      phase, phase_next;
  logic [2:0]  field_byte_index, field_byte_index_next;
  logic [63:0] field_accumulator, field_accumulator_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic        seg_single, seg_single_next;
  logic        checksum_present, checksum_present_next;
  logic [1:0]  content_size_code, content_size_code_next;
  logic [2:0]  dictionary_bytes, dictionary_bytes_next;
  logic [63:0] window_bytes, window_bytes_next;
  logic [63:0] content_bytes, content_bytes_next;
  logic        content_known, content_known_next;
  logic [BMW-1:0] block_max, block_max_next;
  logic [20:0] block_remaining, block_remaining_next;
  logic        block_over_limit, block_over_limit_next;
  logic        final_block, final_block_next;
  logic [31:0] frame_produced, frame_produced_next;
  logic [31:0] total_produced, total_produced_next;
  logic        halted_on_error, halted_on_error_next;

  logic        do_dict, do_fcs, do_finish, do_bdone, do_fend;
  logic        failed, emitted;
  logic [3:0]  fail_code;
  logic [1:0]  emit_kind;
  logic [17:0] emit_run;
  logic [63:0] acc_upd;
  logic [3:0]  idx1;
  logic [3:0]  flen;
  logic [63:0] base, wb;
  logic [20:0] bsize;
  logic [1:0]  btype;
  logic [31:0] used;
  logic [20:0] br_dec;
  logic [31:0] skip_dec;
  logic [7:0]  b;
  logic        start;
  phase_t      start_ph;

  always_comb begin
    phase_next = phase;
    field_byte_index_next = field_byte_index;
    field_accumulator_next = field_accumulator;
    skip_remaining_next = skip_remaining;
    seg_single_next = seg_single;
    checksum_present_next = checksum_present;
    content_size_code_next = content_size_code;
    dictionary_bytes_next = dictionary_bytes;
    window_bytes_next = window_bytes;
    content_bytes_next = content_bytes;
    content_known_next = content_known;
    block_max_next = block_max;
    block_remaining_next = block_remaining;
    block_over_limit_next = block_over_limit;
    final_block_next = final_block;
    frame_produced_next = frame_produced;
    total_produced_next = total_produced;
    halted_on_error_next = halted_on_error;
    do_dict = 1'b0; do_fcs = 1'b0; do_finish = 1'b0; do_bdone = 1'b0; do_fend = 1'b0;
    failed = 1'b0; fail_code = ERR_TRUNCATED;
    emitted = 1'b0; emit_kind = RES_LITERAL; emit_run = 18'd1;
    start = 1'b0; start_ph = PH_MAGIC;
    b = item.byte_in;
    acc_upd = field_accumulator | ({56'd0, b} << {field_byte_index, 3'b000});
    idx1 = {1'b0, field_byte_index} + 4'd1;
    flen = fcs_len(content_size_code, seg_single);
    base = 64'd1 << (6'd10 + {3'd0, b[7:3]});
    wb = 64'd0;
    bsize = acc_upd[23:3];
    btype = acc_upd[2:1];
    used = (total_produced < output_limit) ? total_produced : output_limit;
    br_dec = (block_remaining != 21'd0) ? block_remaining - 21'd1 : 21'd0;
    skip_dec = (skip_remaining != 32'd0) ? skip_remaining - 32'd1 : 32'd0;

    if (take && !halted_on_error && item.kind == KIND_BYTE) begin
      // field bytes go into the accumulator until complete
      field_accumulator_next = acc_upd;
      field_byte_index_next = idx1[2:0];
      unique case (phase)
        PH_MAGIC: begin
          if (idx1 >= 4'd4) begin
            if ((acc_upd[31:0] & SKIP_MASK) == SKIP_BASE) begin
              start = 1'b1; start_ph = PH_SKIP_SIZE;
            end else if (acc_upd[31:0] != ZSTD_MAGIC) begin
              failed = 1'b1; fail_code = ERR_BAD_MAGIC;
            end else begin
              start = 1'b1; start_ph = PH_DESC;
            end
          end
        end
        PH_SKIP_SIZE: begin
          if (idx1 >= 4'd4) begin
            skip_remaining_next = acc_upd[31:0];
            start = 1'b1;
            start_ph = (acc_upd[31:0] == 32'd0) ? PH_MAGIC : PH_SKIP_BODY;
          end
        end
        PH_SKIP_BODY: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 32'd0) begin
            start = 1'b1; start_ph = PH_MAGIC;
          end
        end
        PH_DESC: begin
          field_accumulator_next = field_accumulator;
          field_byte_index_next = field_byte_index;
          content_size_code_next = b[7:6];
          seg_single_next = b[5];
          if (b[3]) begin
            failed = 1'b1; fail_code = ERR_RESERVED_BIT;
          end else begin
            checksum_present_next = b[2];
            dictionary_bytes_next = (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
            window_bytes_next = 64'd0;
            content_bytes_next = 64'd0;
            if (!b[5]) begin
              start = 1'b1; start_ph = PH_WINDOW;
            end else begin
              do_dict = 1'b1;
            end
          end
        end
        PH_WINDOW: begin
          field_accumulator_next = field_accumulator;
          field_byte_index_next = field_byte_index;
          // mantissa eighths added as shifted copies of the base
          window_bytes_next = base + ({64{b[2]}} & (base >> 1)) +
                              ({64{b[1]}} & (base >> 2)) + ({64{b[0]}} & (base >> 3));
          do_dict = 1'b1;
        end
        PH_DICT: begin
          if (idx1 >= {1'b0, dictionary_bytes}) begin
            if (acc_upd != 64'd0) begin
              failed = 1'b1; fail_code = ERR_DICTIONARY;
            end else begin
              do_fcs = 1'b1;
            end
          end
        end
        PH_FCS: begin
          if (idx1 >= flen) begin
            content_bytes_next = acc_upd + ((flen == 4'd2) ? 64'd256 : 64'd0);
            do_finish = 1'b1;
          end
        end
        PH_BLK_HDR: begin
          if (idx1 >= 4'd3) begin
            final_block_next = acc_upd[0];
            if (btype == BTYPE_RSVD) begin
              failed = 1'b1; fail_code = ERR_RESERVED_BLK;
            end else if ({11'd0, bsize} > 32'(block_max)) begin
              failed = 1'b1; fail_code = ERR_BLOCK_BIG;
            end else begin
              block_over_limit_next = {11'd0, bsize} > (output_limit - used);
              block_remaining_next = bsize;
              if (btype == BTYPE_RAW) begin
                if (bsize == 21'd0) begin
                  do_bdone = 1'b1;
                end else begin
                  start = 1'b1; start_ph = PH_RAW;
                end
              end else if (btype == BTYPE_RLE) begin
                start = 1'b1; start_ph = PH_RLE;
              end else if (bsize == 21'd0) begin
                failed = 1'b1; fail_code = ERR_COMPRESSED;
              end else begin
                start = 1'b1; start_ph = PH_COMP;
              end
            end
          end
        end
        PH_RAW: begin
          field_accumulator_next = field_accumulator;
          field_byte_index_next = field_byte_index;
          block_remaining_next = br_dec;
          if (block_over_limit) begin
            if (br_dec == 21'd0) begin
              failed = 1'b1; fail_code = ERR_OUTPUT_LIMIT;
            end
          end else begin
            total_produced_next = total_produced + 32'd1;
            frame_produced_next = frame_produced + 32'd1;
            if (br_dec == 21'd0) do_bdone = 1'b1;
            emitted = 1'b1;
          end
        end
        PH_RLE: begin
          field_accumulator_next = field_accumulator;
          field_byte_index_next = field_byte_index;
          if (block_over_limit) begin
            failed = 1'b1; fail_code = ERR_OUTPUT_LIMIT;
          end else begin
            total_produced_next = total_produced + {11'd0, block_remaining};
            frame_produced_next = frame_produced + {11'd0, block_remaining};
            block_remaining_next = 21'd0;
            do_bdone = 1'b1;
            if (block_remaining != 21'd0) begin
              emitted = 1'b1; emit_kind = RES_RUN;
              emit_run = block_remaining[17:0];
            end
          end
        end
        PH_COMP: begin
          field_accumulator_next = field_accumulator;
          field_byte_index_next = field_byte_index;
          block_remaining_next = br_dec;
          if (br_dec == 21'd0) begin
            failed = 1'b1; fail_code = ERR_COMPRESSED;
          end
        end
        PH_CHECKSUM: begin
          if (idx1 >= 4'd4) do_fend = 1'b1;
        end
        default: begin
          start = 1'b1; start_ph = PH_MAGIC;
        end
      endcase

      // header tail (dict id, content size, checks); block/frame end
      if (do_dict) begin
        if (dictionary_bytes_next == 3'd0) begin
          do_fcs = 1'b1;
        end else begin
          start = 1'b1; start_ph = PH_DICT;
        end
      end
      if (do_fcs) begin
        content_known_next = fcs_len(content_size_code_next, seg_single_next) != 4'd0;
        if (!content_known_next) begin
          do_finish = 1'b1;
        end else begin
          start = 1'b1; start_ph = PH_FCS;
        end
      end
      if (do_finish) begin
        wb = seg_single_next ? content_bytes_next : window_bytes_next;
        window_bytes_next = wb;
        block_max_next = BMW'((wb < CAP64) ? wb : CAP64);
        if (wb == 64'd0 && !seg_single_next) begin
          failed = 1'b1; fail_code = ERR_ZERO_WINDOW;
        end else if (wb > {32'd0, window_limit}) begin
          failed = 1'b1; fail_code = ERR_WINDOW_LIMIT;
        end else if (content_known_next && content_bytes_next > {32'd0, output_limit}) begin
          failed = 1'b1; fail_code = ERR_CONTENT_LIM;
        end else if (wb == 64'd0 && (!content_known_next || content_bytes_next != 64'd0)) begin
          failed = 1'b1; fail_code = ERR_ZERO_BLKMAX;
        end else begin
          frame_produced_next = 32'd0;
          start = 1'b1; start_ph = PH_BLK_HDR;
        end
      end
      if (do_bdone) begin
        if (!final_block_next) begin
          start = 1'b1; start_ph = PH_BLK_HDR;
        end else if (checksum_present_next) begin
          start = 1'b1; start_ph = PH_CHECKSUM;
        end else begin
          do_fend = 1'b1;
        end
      end
      if (do_fend) begin
        if (content_known_next && {32'd0, frame_produced_next} != content_bytes_next) begin
          failed = 1'b1; fail_code = ERR_SIZE_MISMATCH;
        end else begin
          start = 1'b1; start_ph = PH_MAGIC;
        end
      end
      if (start) begin
        phase_next = start_ph;
        field_byte_index_next = 3'd0;
        field_accumulator_next = 64'd0;
      end
      if (failed) halted_on_error_next = 1'b1;
    end

    res_valid = 1'b0;
    res = '{result_kind: RES_LITERAL, byte_out: b, run_length: emit_run,
            error_code: ERR_TRUNCATED, stream_last: 1'b0};
    if (take && item.kind == KIND_END) begin
      res_valid = !halted_on_error;
      res.byte_out = 8'd0;
      res.run_length = 18'd0;
      res.stream_last = 1'b1;
      res.result_kind = (phase == PH_MAGIC && field_byte_index == 3'd0) ? RES_DONE : RES_ERROR;
    end else if (failed) begin
      res_valid = 1'b1;
      res = '{result_kind: RES_ERROR, byte_out: 8'd0, run_length: 18'd0,
              error_code: fail_code, stream_last: 1'b1};
    end else if (emitted) begin
      res_valid = 1'b1;
      res.result_kind = emit_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.kind == KIND_END)) begin
      phase <= PH_MAGIC;
      field_byte_index <= '0;
      field_accumulator <= '0;
      skip_remaining <= '0;
      seg_single <= 1'b0;
      checksum_present <= 1'b0;
      content_size_code <= '0;
      dictionary_bytes <= '0;
      window_bytes <= '0;
      content_bytes <= '0;
      content_known <= 1'b0;
      block_max <= '0;
      block_remaining <= '0;
      block_over_limit <= 1'b0;
      final_block <= 1'b0;
      frame_produced <= '0;
      total_produced <= '0;
      halted_on_error <= 1'b0;
    end else begin
      phase <= phase_next;
      field_byte_index <= field_byte_index_next;
      field_accumulator <= field_accumulator_next;
      skip_remaining <= skip_remaining_next;
      seg_single <= seg_single_next;
      checksum_present <= checksum_present_next;
      content_size_code <= content_size_code_next;
      dictionary_bytes <= dictionary_bytes_next;
      window_bytes <= window_bytes_next;
      content_bytes <= content_bytes_next;
      content_known <= content_known_next;
      block_max <= block_max_next;
      block_remaining <= block_remaining_next;
      block_over_limit <= block_over_limit_next;
      final_block <= final_block_next;
      frame_produced <= frame_produced_next;
      total_produced <= total_produced_next;
      halted_on_error <= halted_on_error_next;
    end
  end

endmodule

// ===== sv/zfrd_checker.sv =====
module zfrd_checker import zfrd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with empty result register");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.stream_last |->
      result.result_kind == RES_DONE || result.result_kind == RES_ERROR)
    else $error("stream end on data result");

  a_literal_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.result_kind == RES_LITERAL |-> result.run_length == 18'd1)
    else $error("literal with count other than one");

endmodule

bind zstd_frame_raw_rle_decoder_unit zfrd_checker u_zfrd_checker (
  .clk(clk), .rst(rst), .item_stall(item_stall),
  .result_valid(result_valid), .result_stall(result_stall), .result(result)
);

// ===== verif/zstd_frame_raw_rle_decoder_unit_tb.sv =====
module zstd_frame_raw_rle_decoder_unit_tb;
  import zfrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] BLOCK_CAP = 64'd131072;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  zstd_frame_raw_rle_decoder_unit DUT (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  item_t   feed_q[$];
  result_t decoded_q[$];
  int      mismatches = 0;
  int      word_count = 0;
  bit      took = 0;
  bit      quiet = 0;
  bit      hold_req = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      hold_left = 0;

  // parser mirror
  logic [31:0] lim_out, lim_win;
  phase_t      ph;
  int unsigned fidx;
  logic [63:0] facc;
  logic [31:0] skip_rem;
  bit          sseg, cks, cknown, over, fin, halted;
  logic [1:0]  fcs_code;
  int unsigned dict_n;
  logic [63:0] win, content;
  logic [31:0] blk_max, blk_rem, frame_out, total_out;
  bit          got;
  result_t     got_res;
  result_t     want;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("zstd_frame_raw_rle_decoder_unit verification failed");
    $finish;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic clear_stream();
    ph = PH_MAGIC; fidx = 0; facc = '0; skip_rem = '0; sseg = 0; cks = 0;
    fcs_code = '0; dict_n = 0; win = '0; content = '0; cknown = 0; blk_max = '0;
    blk_rem = '0; over = 0; fin = 0; frame_out = '0; total_out = '0; halted = 0;
  endtask

  task automatic post_result(input logic [1:0] k, input logic [7:0] b,
                             input logic [17:0] run, input logic [3:0] code,
                             input logic last);
    got = 1;
    got_res = '{result_kind: k, byte_out: b, run_length: run, error_code: code,
                stream_last: last};
  endtask

  task automatic raise_error(input logic [3:0] code);
    halted = 1;
    post_result(RES_ERROR, 8'd0, 18'd0, code, 1'b1);
  endtask

  task automatic restart(input phase_t p);
    ph = p; fidx = 0; facc = '0;
  endtask

  function automatic int unsigned fcs_bytes();
    case (fcs_code)
      2'd0: return sseg ? 1 : 0;
      2'd1: return 2;
      2'd2: return 4;
      default: return 8;
    endcase
  endfunction

  function automatic bit gather(input logic [7:0] b, input int unsigned len);
    int unsigned i;
    i = fidx & 7;
    facc |= 64'(b) << (8 * i);
    if (i + 1 >= len) return 1;
    fidx = i + 1;
    return 0;
  endfunction

  task automatic finish_header();
    logic [63:0] bm;
    if (sseg) win = content;
    if (win == 0 && !sseg) raise_error(ERR_ZERO_WINDOW);
    else if (win > {32'd0, lim_win}) raise_error(ERR_WINDOW_LIMIT);
    else if (cknown && content > {32'd0, lim_out}) raise_error(ERR_CONTENT_LIM);
    else begin
      bm = win < BLOCK_CAP ? win : BLOCK_CAP;
      blk_max = bm[31:0];
      if (blk_max == 0 && (!cknown || content != 0)) raise_error(ERR_ZERO_BLKMAX);
      else begin
        frame_out = '0;
        restart(PH_BLK_HDR);
      end
    end
  endtask

  task automatic enter_fcs();
    cknown = fcs_bytes() != 0;
    if (!cknown) finish_header();
    else restart(PH_FCS);
  endtask

  task automatic enter_dict();
    if (dict_n == 0) enter_fcs();
    else restart(PH_DICT);
  endtask

  task automatic frame_end();
    if (cknown && {32'd0, frame_out} != content) raise_error(ERR_SIZE_MISMATCH);
    else restart(PH_MAGIC);
  endtask

  task automatic block_done();
    if (!fin) restart(PH_BLK_HDR);
    else if (cks) restart(PH_CHECKSUM);
    else frame_end();
  endtask

  task automatic read_blk_hdr(input logic [23:0] h);
    logic [1:0]  btype;
    logic [31:0] size, used;
    btype = h[2:1];
    size = {11'd0, h[23:3]};
    used = total_out < lim_out ? total_out : lim_out;
    fin = h[0];
    if (btype == BTYPE_RSVD) raise_error(ERR_RESERVED_BLK);
    else if (size > blk_max) raise_error(ERR_BLOCK_BIG);
    else begin
      over = size > lim_out - used;
      blk_rem = size;
      if (btype == BTYPE_RAW) begin
        if (size == 0) block_done();
        else restart(PH_RAW);
      end else if (btype == BTYPE_RLE) begin
        restart(PH_RLE);
      end else if (size == 0) begin
        raise_error(ERR_COMPRESSED);
      end else begin
        restart(PH_COMP);
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] n;
    logic [63:0] base;
    case (ph)
      PH_MAGIC: if (gather(b, 4)) begin
        n = facc[31:0];
        if ((n & SKIP_MASK) == SKIP_BASE) restart(PH_SKIP_SIZE);
        else if (n != ZSTD_MAGIC) raise_error(ERR_BAD_MAGIC);
        else restart(PH_DESC);
      end
      PH_SKIP_SIZE: if (gather(b, 4)) begin
        skip_rem = facc[31:0];
        restart(skip_rem == 0 ? PH_MAGIC : PH_SKIP_BODY);
      end
      PH_SKIP_BODY: begin
        if (skip_rem > 0) skip_rem--;
        if (skip_rem == 0) restart(PH_MAGIC);
      end
      PH_DESC: begin
        fcs_code = b[7:6];
        sseg = b[5];
        if (b[3]) raise_error(ERR_RESERVED_BIT);
        else begin
          cks = b[2];
          dict_n = b[1:0] == 2'd3 ? 4 : b[1:0];
          win = '0;
          content = '0;
          if (!sseg) restart(PH_WINDOW);
          else enter_dict();
        end
      end
      PH_WINDOW: begin
        base = 64'd1 << (10 + b[7:3]);
        win = base + (base >> 3) * b[2:0];
        enter_dict();
      end
      PH_DICT: if (gather(b, dict_n)) begin
        if (facc != 0) raise_error(ERR_DICTIONARY);
        else enter_fcs();
      end
      PH_FCS: if (gather(b, fcs_bytes())) begin
        content = facc;
        if (fcs_bytes() == 2) content += 256;
        finish_header();
      end
      PH_BLK_HDR: if (gather(b, 3)) read_blk_hdr(facc[23:0]);
      PH_RAW: begin
        if (blk_rem > 0) blk_rem--;
        if (over) begin
          if (blk_rem == 0) raise_error(ERR_OUTPUT_LIMIT);
        end else begin
          total_out++;
          frame_out++;
          if (blk_rem == 0) block_done();
          // a size mismatch on the last byte wins over the literal
          if (!got) post_result(RES_LITERAL, b, 18'd1, ERR_TRUNCATED, 1'b0);
        end
      end
      PH_RLE: begin
        if (over) raise_error(ERR_OUTPUT_LIMIT);
        else begin
          n = blk_rem;
          total_out += n;
          frame_out += n;
          blk_rem = '0;
          block_done();
          if (!got && n != 0) post_result(RES_RUN, b, n[17:0], ERR_TRUNCATED, 1'b0);
        end
      end
      PH_COMP: begin
        if (blk_rem > 0) blk_rem--;
        if (blk_rem == 0) raise_error(ERR_COMPRESSED);
      end
      PH_CHECKSUM: if (gather(b, 4)) frame_end();
      default: restart(PH_MAGIC);
    endcase
  endtask

  task automatic decode_word(input item_t w);
    got = 0;
    if (w.kind == KIND_END) begin
      if (!halted) begin
        if (ph == PH_MAGIC && fidx == 0)
          post_result(RES_DONE, 8'd0, 18'd0, ERR_TRUNCATED, 1'b1);
        else
          raise_error(ERR_TRUNCATED);
      end
      clear_stream();
    end else if (!halted) begin
      parse_byte(w.byte_in);
    end
  endtask

  // stream building
  task automatic push_byte(input logic [7:0] b);
    feed_q.push_back('{kind: KIND_BYTE, byte_in: b});
    word_count++;
  endtask

  task automatic push_end();
    feed_q.push_back('{kind: KIND_END, byte_in: 8'($urandom)});
    word_count++;
  endtask

  task automatic push_le(input logic [63:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8]);
  endtask

  task automatic add_frame();
    int          nblk, total, r, code;
    int          sz[4];
    logic [1:0]  bt[4];
    bit          single, sum_on;
    logic [63:0] cval;
    logic [7:0]  desc, dcode;
    nblk = $urandom_range(1, 4);
    total = 0;
    for (int i = 0; i < nblk; i++) begin
      r = $urandom_range(0, 19);
      if (r < 10) begin
        bt[i] = BTYPE_RAW; sz[i] = $urandom_range(0, 10);
      end else if (r < 18) begin
        bt[i] = BTYPE_RLE;
        sz[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(0, 40);
      end else begin
        bt[i] = (r == 18) ? BTYPE_COMP : BTYPE_RSVD; sz[i] = $urandom_range(0, 3);
      end
      if (bt[i] == BTYPE_RAW || bt[i] == BTYPE_RLE) total += sz[i];
    end
    single = $urandom_range(0, 3) == 0;
    if (single) code = total < 256 ? 0 : 1;
    else begin
      code = $urandom_range(0, 3);
      if (code == 1 && total < 256) code = 2;
    end
    cval = total;
    if (code >= 2 && $urandom_range(0, 11) == 0) cval = cval + 1;
    sum_on = $urandom_range(0, 1);
    dcode = ($urandom_range(0, 14) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
    desc = 8'(code << 6) | (single ? 8'h20 : 8'h00) | (sum_on ? 8'h04 : 8'h00) | dcode;
    if ($urandom_range(0, 29) == 0) desc[3] = 1'b1;
    push_le(64'(ZSTD_MAGIC), 4);
    push_byte(desc);
    if (!single)
      push_byte(($urandom_range(0, 14) == 0) ? 8'($urandom) :
                {5'($urandom_range(0, 3)), 3'($urandom)});
    if (dcode != 0)
      push_le(($urandom_range(0, 2) == 0) ? 64'($urandom) : 64'd0,
              (dcode == 8'd3) ? 4 : int'(dcode));
    case (code)
      0: if (single) push_le(cval, 1);
      1: push_le(cval - 256, 2);
      2: push_le(cval, 4);
      default: push_le(cval, 8);
    endcase
    for (int i = 0; i < nblk; i++) begin
      push_le({sz[i][20:0], bt[i], (i == nblk - 1) ? 1'b1 : 1'b0}, 3);
      if (bt[i] == BTYPE_RLE) push_byte(8'($urandom));
      else if (bt[i] != BTYPE_RSVD)
        for (int j = 0; j < sz[i]; j++) push_byte(8'($urandom));
    end
    if (sum_on) push_le(64'($urandom), 4);
  endtask

  task automatic add_stream();
    int start, nfr, r, sk;
    start = feed_q.size();
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom));
    end else begin
      nfr = $urandom_range(0, 3);
      for (int i = 0; i < nfr; i++) begin
        if ($urandom_range(0, 5) == 0) begin
          sk = $urandom_range(0, 5);
          push_le({32'd0, SKIP_BASE | 32'($urandom_range(0, 15))}, 4);
          push_le(64'(sk), 4);
          repeat (sk) push_byte(8'($urandom));
        end else begin
          add_frame();
        end
      end
      r = $urandom_range(0, 9);
      if (r == 0 && feed_q.size() > start) begin
        feed_q[$urandom_range(start, feed_q.size() - 1)].byte_in = 8'($urandom);
      end else if (r == 1) begin
        repeat ($urandom_range(1, 4)) begin
          if (feed_q.size() > start) void'(feed_q.pop_back());
        end
      end else if (r == 2) begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
      end
    end
    push_end();
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_OUTPUT_LIMIT) lim_out = val;
    else if (idx == REG_WINDOW_LIMIT) lim_win = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (feed_q.size() != 0 || item_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !took) begin
      // stalled word stays put
    end else if (gap_left > 0) begin
      gap_left--;
      item_valid <= 1'b0;
    end else if (feed_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
      gap_left = $urandom_range(1, 6) - 1;
      item_valid <= 1'b0;
    end else if (feed_q.size() > 0) begin
      item <= feed_q.pop_front();
      item_valid <= 1'b1;
    end else begin
      item_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 299;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    took = 0;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected result word %h", result));
        end else begin
          want = decoded_q.pop_front();
          if (result.result_kind !== want.result_kind)
            report($sformatf("result_kind %0d, wanted %0d", result.result_kind,
                             want.result_kind));
          if (result.byte_out !== want.byte_out)
            report($sformatf("byte_out %h, wanted %h", result.byte_out, want.byte_out));
          if (result.run_length !== want.run_length)
            report($sformatf("run_length %0d, wanted %0d", result.run_length,
                             want.run_length));
          if (result.error_code !== want.error_code)
            report($sformatf("error_code %0d, wanted %0d", result.error_code,
                             want.error_code));
          if (result.stream_last !== want.stream_last)
            report($sformatf("stream_last %b, wanted %b", result.stream_last,
                             want.stream_last));
        end
      end
      if (item_valid && !item_stall) begin
        took = 1;
        decode_word(item);
        if (got) decoded_q.push_back(got_res);
      end
    end
  end

  initial begin
    logic [31:0] out_set[6];
    logic [31:0] win_set[6];
    int target;
    out_set = '{32'hffffffff, 32'd40, 32'd16777216, 32'd0, 32'd1000, 32'd16777216};
    win_set = '{32'hffffffff, 32'd2048, 32'd8388608, 32'd0, 32'd1024, 32'd8388608};
    clear_stream();
    lim_out = 32'd16777216;
    lim_win = 32'd8388608;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // empty stream, bad magic, reserved descriptor bit, empty single-segment frame
    push_end();
    push_le(64'd0, 4);
    push_end();
    push_le(64'(ZSTD_MAGIC), 4);
    push_byte(8'h08);
    push_end();
    push_le(64'(ZSTD_MAGIC), 4);
    push_byte(8'h20);
    push_byte(8'h00);
    push_le({21'd0, BTYPE_RAW, 1'b1}, 3);
    push_end();
    for (int p = 0; p < 6; p++) begin
      settle();
      write_reg(REG_OUTPUT_LIMIT, out_set[p]);
      write_reg(REG_WINDOW_LIMIT, win_set[p]);
      if (p == 5) quiet = 1;
      target = word_count + 270;
      while (word_count < target) add_stream();
      if (p == 2) hold_req = 1;
    end
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("zstd_frame_raw_rle_decoder_unit verification clean");
    else
      $display("zstd_frame_raw_rle_decoder_unit verification failed");
    $finish;
  end

endmodule

// ===== zstd_frame_raw_rle_decoder_unit.f =====
sv/zfrd_pkg.sv
sv/zfrd_parser.sv
sv/zstd_frame_raw_rle_decoder_unit.sv
sv/zfrd_checker.sv
verif/zstd_frame_raw_rle_decoder_unit_tb.sv
